/* hdl/lgu_pkg.sv */
`timescale 1ns / 1ps
package lgu_pkg;

  localparam int PredWidth = 24;
  localparam int SumWidth  = 48;
  localparam int LossWidth = 31;
  localparam int RowWidth  = 11;
  localparam int MaxRows   = 1024;
  localparam int Ln2Q16    = 45426;

  localparam int LogTableDepth = 256;
  localparam int LogTableBits  = 8;

  localparam logic [0:0] RegLossMode = 1'b0;
  localparam logic [0:0] RegRowCount = 1'b1;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctrl_t;

  typedef logic [LogTableDepth-1:0][15:0] log_table_t;

  // Entry i holds log2(1 + i/depth) as a 16-bit fraction, found by repeated squaring.
  function automatic log_table_t build_log_table();
    log_table_t  tbl;
    logic [63:0] x;
    logic [15:0] r;
    for (int i = 0; i < LogTableDepth; i++) begin
      x = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          r[15 - k] = 1'b1;
        end
      end
      tbl[i] = r;
    end
    return tbl;
  endfunction

  // Fixed contents, worked out once when the design is elaborated.
  localparam log_table_t LogTable = build_log_table();

endpackage

/* hdl/loss_and_gradient_unit.sv */
`timescale 1ns / 1ps
// Order of steps: an MSE element passes the log, calc and accumulate states before the output
// state; a BCE element also waits in the gradient state on the shared 64-step divider, and a
// last element with a positive sum spends a further run in the same divider for the mean.
// Flow control: one element at a time; s_tready is low from acceptance until the result
// has been taken, so the block does not take a new element before the last one is through.
// Reset (rst, synchronous): mode MSE, row count 1, loss sum zero, output empty.
module loss_and_gradient_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pred_value[23:0], target_value[47:24]
  input  logic        s_tlast,   // last_element
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // grad_value[23:0], loss_value[54:24], zero pad
  output logic [1:0]  m_tuser,   // grad_saturated[0], loss_valid[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCalc  = 3'd1;
  localparam logic [2:0] StGrad  = 3'd2;
  localparam logic [2:0] StAcc   = 3'd3;
  localparam logic [2:0] StMean  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam logic [2:0] StLog   = 3'd6;

  logic [2:0] state;
  logic       loss_mode;
  logic [10:0] row_count;
  logic signed [47:0] loss_sum;

  logic signed [24:0] t_in, pc;
  logic        last_q, mode_q;
  logic signed [25:0] n;
  logic signed [49:0] elem;       // element loss, Q16
  logic signed [25:0] grad_raw;
  logic signed [23:0] grad_value;
  logic        grad_sat;
  logic [30:0] loss_value;
  logic        loss_valid;
  logic        neg_grad;
  logic signed [66:0] bce_acc;
  logic [19:0] l1, l0;

  // Shared divider.
  logic        div_start;
  logic [63:0] div_dividend;
  logic [32:0] div_divisor;
  logic [63:0] div_q;
  lgu_pkg::div_ctrl_t div_ctrl;

  lgu_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(div_q), .ctrl(div_ctrl)
  );

  // Negative natural log of a Q16 value in [1, 65535] via the log2 table.
  // The result reaches 16 ln 2 in Q16 for the smallest input, so it needs 20 bits.
  function automatic logic [19:0] neg_ln(input logic [15:0] v);
    logic [3:0]  e;
    logic [15:0] m;
    logic [20:0] nl2;
    logic [37:0] prod;
    e = 4'd0;
    for (int b = 0; b < 16; b++) if (v[b]) e = 4'(b);
    m = v << (4'd15 - e);
    nl2 = (21'(5'd16 - {1'b0, e}) << 16)
          - 21'(lgu_pkg::LogTable[m[14 -: lgu_pkg::LogTableBits]]);
    prod = 38'(nl2) * 38'(lgu_pkg::Ln2Q16) + 38'd32768;
    return prod[35:16];
  endfunction

  logic [10:0] rows_eff;
  assign rows_eff = (row_count == '0) ? 11'd1 :
                    (row_count > 11'(lgu_pkg::MaxRows)) ? 11'(lgu_pkg::MaxRows) : row_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      loss_mode <= 1'b0;
      row_count <= 11'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lgu_pkg::RegLossMode: loss_mode <= cfg_data[0];
        lgu_pkg::RegRowCount: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = state == StIdle;

  logic signed [48:0] sum_add;
  logic signed [47:0] sum_sat;
  logic signed [49:0] round_src;
  assign sum_add = 49'(loss_sum) + 49'(elem);
  // The running sum clips at the ends of its 48-bit range.
  assign sum_sat = sum_add > 49'sh7FFF_FFFF_FFFF ? 48'sh7FFF_FFFF_FFFF :
                   sum_add < -49'sh8000_0000_0000 ? 48'sh8000_0000_0000 : 48'(sum_add);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (state == StCalc && mode_q) begin
      div_start    = 1'b1;
      div_dividend = {6'd0, (n < 0 ? 26'(-n) : 26'(n)), 32'd0};
      div_divisor  = 33'(34'(25'sd65536 - pc) * 34'(pc));
    end else if (state == StAcc && last_q && sum_sat > 0) begin
      // The mean is taken over the sum including the current element.
      div_start    = 1'b1;
      div_dividend = 64'(sum_sat);
      div_divisor  = 33'(rows_eff);
    end
  end

  assign round_src = 50'(bce_acc >= 0 ? (bce_acc + 67'sd32768) >>> 16
                                      : -((-bce_acc + 67'sd32767) >>> 16));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= StIdle;
      m_tvalid <= 1'b0;
      loss_sum <= '0;
    end else begin
      unique case (state)
        StIdle: if (s_tvalid) begin
          t_in   <= 25'(signed'(s_tdata[47:24]));
          pc     <= loss_mode ? ((signed'(s_tdata[23:0]) < 1) ? 25'sd1 :
                    (signed'(s_tdata[23:0]) > 65535) ? 25'sd65535 :
                    25'(signed'(s_tdata[23:0]))) : 25'(signed'(s_tdata[23:0]));
          last_q <= s_tlast;
          mode_q <= loss_mode;
          state  <= StLog;
        end
        StLog: begin
          n  <= 26'(pc) - 26'(t_in);
          l1 <= neg_ln(pc[15:0]);
          l0 <= neg_ln(16'(25'sd65536 - pc));
          state <= StCalc;
        end
        StCalc: begin
          neg_grad <= n < 0;
          if (!mode_q) begin
            grad_raw <= n <<< 1;
            elem     <= 50'((52'(n) * 52'(n) + 52'sd32768) >>> 16);
            state    <= StAcc;
          end else begin
            bce_acc <= 67'(t_in) * 67'(l1) + (67'sd65536 - 67'(t_in)) * 67'(l0);
            state   <= StGrad;
          end
        end
        StGrad: begin
          elem <= round_src;
          if (div_ctrl.done) begin
            grad_raw <= (div_q > 64'd8388608) ? (neg_grad ? -26'sd8388609 : 26'sd8388608)
                        : (neg_grad ? -26'(div_q) : 26'(div_q));
            state <= StAcc;
          end
        end
        StAcc: begin
          grad_sat   <= grad_raw > 26'sd8388607 || grad_raw < -26'sd8388608;
          grad_value <= grad_raw > 26'sd8388607 ? 24'sh7FFFFF :
                        grad_raw < -26'sd8388608 ? 24'sh800000 : 24'(grad_raw);
          // A last element with nothing positive to average clears the sum at once.
          loss_sum   <= (last_q && sum_sat <= 0) ? 48'sd0 : sum_sat;
          loss_valid <= last_q;
          loss_value <= '0;
          if (last_q && sum_sat > 0) state <= StMean;
          else state <= StOut;
        end
        StMean: begin
          if (div_ctrl.done) begin
            loss_value <= (div_q > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(div_q);
            loss_sum   <= '0;
            state      <= StOut;
          end
        end
        StOut: begin
          if (!m_tvalid) m_tvalid <= 1'b1;
          else if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  assign m_tdata = {1'b0, (loss_valid ? loss_value : 31'd0), grad_value};
  assign m_tuser = {loss_valid, grad_sat};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_sum_clear: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && loss_valid) |-> loss_sum == '0) else $error("sum not cleared");
  a_valid_only_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> state == StOut) else $error("result outside output state");

endmodule

/* hdl/lgu_divider.sv */
`timescale 1ns / 1ps
// Restoring radix-2 divider, one quotient bit per cycle over 64 bits of dividend.
module lgu_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic [63:0] quotient,
  output lgu_pkg::div_ctrl_t ctrl
);

  logic [6:0]  count;
  logic [63:0] quo;
  logic [33:0] rem;
  logic [32:0] dsr;
  logic [33:0] trial;
  logic        done_q;

  assign trial = {rem[32:0], quo[63]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        count <= 7'd64;
      end else if (count != '0) begin
        count <= count - 7'd1;
        if (count == 7'd1) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      if (!trial[33]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= {rem[32:0], quo[63]};
        quo <= {quo[62:0], 1'b0};
      end
    end
  end

  assign quotient   = quo;
  assign ctrl.start = start;
  assign ctrl.busy  = count != '0;
  assign ctrl.done  = done_q;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |-> $past(count) == 7'd1) else $error("divider done without final step");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    ctrl.busy |=> !$past(start) || count == 7'd64) else $error("divider count lost");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    ctrl.done |=> !ctrl.done) else $error("divider done held");

endmodule

/* dv/loss_and_gradient_unit_test.sv */
`timescale 1ns / 1ps
module loss_and_gradient_unit_test;

  localparam int CycleLimit = 3000000;
  localparam int DrainWait  = 300;
  localparam int HoldCycles = 400;

  // One element pair waiting to be offered on the slave side.
  typedef struct {
    logic [23:0] pred;
    logic [23:0] targ;
    logic        last;
  } element_t;

  // What the block should return for one accepted element.
  typedef struct {
    logic [23:0] grad;
    logic        sat;
    logic [30:0] loss;
    logic        loss_ok;
  } grad_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // pred_value[23:0], target_value[47:24]
  logic        s_tlast;   // last_element
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // grad_value[23:0], loss_value[54:24], zero pad
  logic [1:0]  m_tuser;   // grad_saturated[0], loss_valid[1]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [10:0] cfg_data;

  loss_and_gradient_unit i_dut (.*);

  element_t     element_q[$];
  grad_result_t expected_q[$];

  // Our own copy of the block's state and registers.
  logic        mode_bce;
  logic [10:0] rows_reg;
  longint      loss_acc;
  logic [15:0] log2_mant[256];

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  took;
  int  hold_reqs;
  int  hold_served;
  int  hold_left;
  int  cycles;
  int  errors;
  int  n_accepted;
  int  n_results;
  int  n_losses;
  int  n_saturated;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR result %0d: %s got 0x%0h, want 0x%0h", n_results, what, got, want);
    errors++;
  endtask

  // log2 mantissa table: log2(1 + i/256) as a 16-bit fraction, built by squaring in Q2.30.
  function automatic void build_log_table();
    longint unsigned x;
    logic [15:0] r;
    for (int i = 0; i < 256; i++) begin
      x = (64'd1 << 30) + (64'(i) << 22);
      r = '0;
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          r[15 - k] = 1'b1;
        end
      end
      log2_mant[i] = r;
    end
  endfunction

  // -ln(v / 2^16) in Q16 for v in [1, 65535].
  function automatic longint unsigned neg_ln(input int unsigned v);
    int e;
    int unsigned m;
    int unsigned idx;
    longint unsigned nl2;
    e = 15;
    while (e > 0 && v[e] == 1'b0) e--;
    m = (v << (15 - e)) & 32'hFFFF;
    idx = (m - 32768) >> 7;
    nl2 = longint'(16 - e) * 65536 - log2_mant[idx];
    return (nl2 * 45426 + 32768) >> 16;
  endfunction

  // Works out the gradient, adds the element loss to the sum and, on a last element, the mean loss.
  function automatic grad_result_t loss_and_grad(input logic [23:0] pred_bits,
                                                 input logic [23:0] targ_bits,
                                                 input logic last);
    grad_result_t r;
    longint p, t, d, g, pc, n, q, elem, x, rows, mean;
    longint unsigned mag, den;
    p = longint'($signed(pred_bits));
    t = longint'($signed(targ_bits));
    r.sat = 1'b0;
    if (!mode_bce) begin
      d = p - t;
      g = 2 * d;
      elem = (d * d + 32768) >>> 16;
    end else begin
      pc = p < 1 ? 1 : (p > 65535 ? 65535 : p);
      n = pc - t;
      mag = n < 0 ? -n : n;
      den = (65536 - pc) * pc;
      q = longint'((mag << 32) / den);
      g = n < 0 ? -q : q;
      x = t * longint'(neg_ln(pc)) + (65536 - t) * longint'(neg_ln(65536 - pc));
      if (x >= 0) elem = (x + 32768) >>> 16;
      else elem = -((32767 - x) >>> 16);
    end
    // Gradients beyond the Q8.16 range are clipped and flagged.
    if (g > 8388607) begin
      g = 8388607;
      r.sat = 1'b1;
    end else if (g < -8388608) begin
      g = -8388608;
      r.sat = 1'b1;
    end
    r.grad = g[23:0];
    loss_acc += elem;
    if (loss_acc > 64'sh7FFF_FFFF_FFFF) loss_acc = 64'sh7FFF_FFFF_FFFF;
    if (loss_acc < -64'sh8000_0000_0000) loss_acc = -64'sh8000_0000_0000;
    r.loss = '0;
    r.loss_ok = last;
    if (last) begin
      // A zero row count divides by one; counts above the maximum are clamped.
      rows = rows_reg == 0 ? 1 : longint'(rows_reg);
      if (rows > lgu_pkg::MaxRows) rows = lgu_pkg::MaxRows;
      mean = 0;
      if (loss_acc > 0) begin
        mean = loss_acc / rows;
        if (mean > 64'd2147483647) mean = 64'd2147483647;
      end
      r.loss = mean[30:0];
      loss_acc = 0;
    end
    return r;
  endfunction

  // Driver: a new transaction is offered once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || took)) begin
      if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tdata  <= {element_q[0].targ, element_q[0].pred};
        s_tlast  <= element_q[0].last;
        s_tvalid <= 1'b1;
        void'(element_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure; a long hold is served here when one is requested.
  always @(negedge clk) begin
    if (hold_reqs != hold_served) begin
      hold_served = hold_served + 1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // Monitor: register writes and input transactions feed the predictor, results are checked.
  always @(posedge clk) begin
    grad_result_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, expected_q.size());
      $display("loss_and_gradient_unit: mismatch");
      $finish;
    end else if (!rst) begin
      took <= s_tvalid && s_tready;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lgu_pkg::RegLossMode) mode_bce = cfg_data[0];
        else rows_reg = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(loss_and_grad(s_tdata[23:0], s_tdata[47:24], s_tlast));
        n_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("ERROR: result with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[23:0] !== want.grad) report("grad_value", m_tdata[23:0], want.grad);
          if (m_tuser[0] !== want.sat) report("grad_saturated", m_tuser[0], want.sat);
          if (m_tdata[54:24] !== want.loss) report("loss_value", m_tdata[54:24], want.loss);
          if (m_tuser[1] !== want.loss_ok) report("loss_valid", m_tuser[1], want.loss_ok);
          if (want.loss_ok) n_losses++;
          if (want.sat) n_saturated++;
        end
        n_results++;
      end
    end
  end

  task automatic add_element(input int p, input int t, input bit last);
    element_t e;
    e.pred = p[23:0];
    e.targ = t[23:0];
    e.last = last;
    element_q.push_back(e);
  endtask

  // About half probabilities and labels near [0, 1], the rest full-range noise or close wide-range pairs.
  task automatic add_random_element();
    int p, t;
    case ($urandom_range(9))
      0, 1: begin
        p = $urandom;
        t = $urandom;
      end
      2, 3, 4, 5: begin
        p = $urandom_range(65600) - 50;
        t = $urandom_range(65536);
      end
      6: begin
        p = $urandom_range(1) ? $urandom_range(300) : 65535 - $urandom_range(300);
        t = $urandom_range(1) ? 65536 : 0;
      end
      default: begin
        t = $urandom_range(2000000) - 1000000;
        p = t + $urandom_range(20000) - 10000;
      end
    endcase
    add_element(p, t, $urandom_range(7) == 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [10:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every offered element has been taken and every result has come back.
  task automatic wait_drained();
    while (element_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = lgu_pkg::RegLossMode;
    cfg_data  = '0;
    mode_bce  = 1'b0;
    rows_reg  = 11'd1;
    loss_acc  = 0;
    send_idle_pct = 27;
    recv_idle_pct = 85;
    build_log_table();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed MSE: field extremes, a saturating gradient and a mean above the loss range.
    add_element(8388607, -8388608, 1'b0);
    add_element(-8388608, 8388607, 1'b1);
    add_element(0, 0, 1'b1);
    add_element(65536, 0, 1'b0);
    add_element(-1, 1, 1'b1);
    add_element(4194303, -4194304, 1'b1);
    wait_drained();

    // Directed BCE: clamping of p at both ends, labels outside [0, 1] driving the sum negative.
    write_reg(lgu_pkg::RegLossMode, 11'd1);
    write_reg(lgu_pkg::RegRowCount, 11'd0);
    add_element(-8388608, 0, 1'b0);
    add_element(0, 65536, 1'b0);
    add_element(1, 0, 1'b0);
    add_element(65535, 65536, 1'b0);
    add_element(65536, 0, 1'b0);
    add_element(8388607, 8388607, 1'b1);
    add_element(32768, 32768, 1'b1);
    add_element(100, -8388608, 1'b1);
    add_element(40000, 8388607, 1'b0);
    add_element(65000, 0, 1'b1);
    wait_drained();

    // Random phases, each under its own register setting; the idling pattern changes at phases 2 and 4.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 85;
        recv_idle_pct = 27;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: begin
          write_reg(lgu_pkg::RegLossMode, 11'd0);
          write_reg(lgu_pkg::RegRowCount, 11'd2047);
        end
        1: begin
          write_reg(lgu_pkg::RegLossMode, 11'd1);
          write_reg(lgu_pkg::RegRowCount, 11'd1024);
        end
        2: begin
          write_reg(lgu_pkg::RegLossMode, 11'd1);
          write_reg(lgu_pkg::RegRowCount, 11'd1);
        end
        3: begin
          write_reg(lgu_pkg::RegLossMode, 11'd0);
          write_reg(lgu_pkg::RegRowCount, 11'd3);
        end
        4: begin
          write_reg(lgu_pkg::RegLossMode, 11'd1);
          write_reg(lgu_pkg::RegRowCount, 11'd1025);
        end
        default: begin
          write_reg(lgu_pkg::RegLossMode, 11'd0);
          write_reg(lgu_pkg::RegRowCount, 11'd0);
        end
      endcase
      for (int i = 0; i < 270; i++) add_random_element();
      // Hold the receiver off while elements keep being offered, so the input stalls.
      if (ph == 4) begin
        repeat (40) @(negedge clk);
        hold_reqs = hold_reqs + 1;
      end
      wait_drained();
    end

    $display("Covered %0d elements in MSE and BCE modes, %0d results, %0d mean losses,",
             n_accepted, n_results, n_losses);
    $display("%0d saturated gradients, row counts from zero to above the maximum.",
             n_saturated);
    if (errors == 0) begin
      $display("loss_and_gradient_unit: match");
    end else begin
      $display("loss_and_gradient_unit: mismatch");
    end
    $finish;
  end

endmodule
